// File: src/modinv_pkg.sv
// Shared types and constants for the modular inverse / divide block.
// No dependencies; imported by the operand channel interface, the block, the checker and the testbench.
`default_nettype none

package modinv_pkg;

    localparam int DIVIDEND_WIDTH = 32;

    // Step counter covers the longest serial pass (one per dividend bit)
    localparam int STEP_CNT_W = $clog2(DIVIDEND_WIDTH);

    localparam logic [31:0] MODULUS_RESET = 32'd998244353;

endpackage : modinv_pkg

`default_nettype wire

// File: src/modinv_if.sv
// Valid/ready channel interfaces: operand request, result and modulus write.
// Depends on modinv_pkg for the dividend width.
`default_nettype none

interface modinv_in_if
    import modinv_pkg::*;
#(
    parameter int MOD_WIDTH = 30
);
    logic                      valid;
    logic                      ready;
    logic [DIVIDEND_WIDTH-1:0] dividend;
    logic [MOD_WIDTH-1:0]      divisor;

    modport source (output valid, dividend, divisor, input ready);
    modport sink   (input valid, dividend, divisor, output ready);
endinterface : modinv_in_if

interface modinv_out_if #(
    parameter int MOD_WIDTH = 30
);
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] inverse;
    logic [MOD_WIDTH-1:0] quotient;

    modport source (output valid, inverse, quotient, input ready);
    modport sink   (input valid, inverse, quotient, output ready);
endinterface : modinv_out_if

interface modinv_cfg_if #(
    parameter int MOD_WIDTH = 30
);
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface : modinv_cfg_if

`default_nettype wire

// File: src/modular_inverse_divide.sv
// Modular inverse by Fermat exponentiation, and modular divide, on one
// serial shift-add-reduce multiplier. Depends on modinv_pkg and modinv_if.sv.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+------------------------------------
//  operands  | in  | valid/ready  | dividend[31:0], divisor[W-1:0]
//  results   | out | valid/ready  | inverse[W-1:0], quotient[W-1:0]
//  cfg       | in  | valid/ready  | data[W-1:0] -> modulus register
//
// One request at a time; each modular product runs on the shared step (one
// multiplier bit per cycle), and so does the dividend reduction. Results are
// valid once the Fermat exponentiation by modulus-2 and the final multiply by
// the reduced dividend are through, and the next request can be taken as soon
// as the result is valid. A modulus below 2 gives zero results, going from
// S_IDLE straight to S_FIN without reduction or exponentiation.
// Reset loads modulus 998244353. The next request is taken while a result
// still waits on results.ready; the block stalls before delivering another.
`default_nettype none

module modular_inverse_divide
    import modinv_pkg::*;
#(
    parameter int MOD_WIDTH = 30
) (
    input  wire             clk,
    input  wire             rst_n,
    modinv_cfg_if.sink      cfg,
    modinv_in_if.sink       operands,
    modinv_out_if.source    results
);

    localparam int W     = MOD_WIDTH;
    localparam int ALIGN = DIVIDEND_WIDTH - MOD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_DVD,
        S_RED_DVS,
        S_PICK,
        S_MUL_ACC,
        S_SQR,
        S_MUL_QUO,
        S_FIN
    } state_t;

    state_t                    state_reg, state_next;
    logic [W-1:0]              mod_reg, mod_next;
    logic                      out_valid_reg, out_valid_next;
    logic [W-1:0]              inv_out_reg, inv_out_next;
    logic [W-1:0]              quo_out_reg, quo_out_next;

    logic [W-1:0]              part_reg, part_next;
    logic [DIVIDEND_WIDTH-1:0] op_sh_reg, op_sh_next;
    logic [W-1:0]              op_x_reg, op_x_next;
    logic                      mult_reg, mult_next;
    logic [STEP_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]              acc_reg, acc_next;
    logic [W-1:0]              base_reg, base_next;
    logic [W-1:0]              dvd_reg, dvd_next;
    logic [W-1:0]              exp_reg, exp_next;

    // shared step: part = (2*part + carry_in + (bit ? x : 0)) mod m
    logic                      cbit, abit;
    logic [W+1:0]              dbl_sum;
    logic [W+2:0]              sub1, sub2;
    logic [W-1:0]              step_out;
    logic                      step_last;
    logic                      op_accept;
    logic                      working;

    assign cbit = ~mult_reg & op_sh_reg[DIVIDEND_WIDTH-1];
    assign abit =  mult_reg & op_sh_reg[DIVIDEND_WIDTH-1];

    assign dbl_sum = (W+2)'({part_reg, cbit}) + (abit ? (W+2)'(op_x_reg) : '0);
    assign sub1    = {1'b0, dbl_sum} - (W+3)'(mod_reg);
    assign sub2    = {1'b0, dbl_sum} - (W+3)'({mod_reg, 1'b0});

    always_comb
    begin
        if (!sub2[W+2])
        begin
            step_out = sub2[W-1:0];
        end
        else if (!sub1[W+2])
        begin
            step_out = sub1[W-1:0];
        end
        else
        begin
            step_out = dbl_sum[W-1:0];
        end
    end

    assign step_last = (cnt_reg == '0);
    assign working   = (state_reg == S_RED_DVD) || (state_reg == S_RED_DVS) ||
                       (state_reg == S_MUL_ACC) || (state_reg == S_SQR) ||
                       (state_reg == S_MUL_QUO);

    assign operands.ready = (state_reg == S_IDLE);
    assign op_accept      = operands.valid && operands.ready;
    assign cfg.ready      = 1'b1;

    assign results.valid    = out_valid_reg;
    assign results.inverse  = inv_out_reg;
    assign results.quotient = quo_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        out_valid_next = out_valid_reg;
        inv_out_next   = inv_out_reg;
        quo_out_next   = quo_out_reg;
        part_next      = part_reg;
        op_sh_next     = op_sh_reg;
        op_x_next      = op_x_reg;
        mult_next      = mult_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        dvd_next       = dvd_reg;
        exp_next       = exp_reg;

        if (cfg.valid)
        begin
            mod_next = cfg.data;
        end

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (working)
        begin
            part_next  = step_out;
            op_sh_next = op_sh_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (op_accept)
                begin
                    op_sh_next = operands.dividend;
                    part_next  = '0;
                    mult_next  = 1'b0;
                    cnt_next   = STEP_CNT_W'(DIVIDEND_WIDTH - 1);
                    base_next  = operands.divisor;
                    if (mod_reg < W'(2))
                    begin
                        acc_next   = '0;
                        dvd_next   = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RED_DVD;
                    end
                end
            end

            S_RED_DVD:
            begin
                if (step_last)
                begin
                    dvd_next   = step_out;
                    op_sh_next = DIVIDEND_WIDTH'(base_reg) << ALIGN;
                    part_next  = '0;
                    cnt_next   = STEP_CNT_W'(W - 1);
                    state_next = S_RED_DVS;
                end
            end

            S_RED_DVS:
            begin
                if (step_last)
                begin
                    base_next  = step_out;
                    acc_next   = W'(1);
                    exp_next   = mod_reg - W'(2);
                    state_next = S_PICK;
                end
            end

            S_PICK:
            begin
                part_next = '0;
                mult_next = 1'b1;
                cnt_next  = STEP_CNT_W'(W - 1);
                if (exp_reg[0])
                begin
                    op_x_next  = base_reg;
                    op_sh_next = DIVIDEND_WIDTH'(acc_reg) << ALIGN;
                    state_next = S_MUL_ACC;
                end
                else if (exp_reg[W-1:1] == '0)
                begin
                    op_x_next  = acc_reg;
                    op_sh_next = DIVIDEND_WIDTH'(dvd_reg) << ALIGN;
                    state_next = S_MUL_QUO;
                end
                else
                begin
                    op_x_next  = base_reg;
                    op_sh_next = DIVIDEND_WIDTH'(base_reg) << ALIGN;
                    state_next = S_SQR;
                end
            end

            S_MUL_ACC:
            begin
                if (step_last)
                begin
                    acc_next  = step_out;
                    part_next = '0;
                    cnt_next  = STEP_CNT_W'(W - 1);
                    // last exponent bit: no further squaring needed
                    if (exp_reg[W-1:1] == '0)
                    begin
                        op_x_next  = step_out;
                        op_sh_next = DIVIDEND_WIDTH'(dvd_reg) << ALIGN;
                        state_next = S_MUL_QUO;
                    end
                    else
                    begin
                        op_x_next  = base_reg;
                        op_sh_next = DIVIDEND_WIDTH'(base_reg) << ALIGN;
                        state_next = S_SQR;
                    end
                end
            end

            S_SQR:
            begin
                if (step_last)
                begin
                    base_next  = step_out;
                    exp_next   = exp_reg >> 1;
                    state_next = S_PICK;
                end
            end

            S_MUL_QUO:
            begin
                if (step_last)
                begin
                    dvd_next   = step_out;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    inv_out_next   = acc_reg;
                    quo_out_next   = dvd_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mod_reg       <= MODULUS_RESET[W-1:0];
            out_valid_reg <= 1'b0;
            inv_out_reg   <= '0;
            quo_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            out_valid_reg <= out_valid_next;
            inv_out_reg   <= inv_out_next;
            quo_out_reg   <= quo_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg  <= part_next;
        op_sh_reg <= op_sh_next;
        op_x_reg  <= op_x_next;
        mult_reg  <= mult_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        dvd_reg   <= dvd_next;
        exp_reg   <= exp_next;
    end

`ifndef SYNTHESIS
    // partial residue stays reduced below the modulus through every multiply and squaring pass
    a_part_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (working && state_reg != S_RED_DVD && state_reg != S_RED_DVS)
            |-> (part_reg < mod_reg))
        else $error("partial product not reduced");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK || state_reg == S_SQR || state_reg == S_MUL_QUO)
            |-> (acc_reg < mod_reg))
        else $error("accumulator not reduced");

    a_small_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (op_accept && mod_reg < W'(2)) |=> (state_reg == S_FIN))
        else $error("degenerate modulus not short-cut");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !results.ready)
            |=> (state_reg == S_FIN && out_valid_reg))
        else $error("pending result overwritten");
`endif

endmodule : modular_inverse_divide

`default_nettype wire

// File: verif/modinv_checker.sv
// Checker for modular_inverse_divide: watches the modulus, operand and result
// channels, predicts inverse and quotient, and compares them in order.
// Depends on modinv_pkg and the channel interfaces in modinv_if.sv.
`default_nettype none

module modinv_checker
    import modinv_pkg::*;
#(
    parameter int MOD_WIDTH = 30
) (
    input  wire     clk,
    input  wire     rst_n,
    modinv_cfg_if   cfg,
    modinv_in_if    operands,
    modinv_out_if   results,
    output int      pending,
    output int      fail_count
);

    typedef struct {
        logic [MOD_WIDTH-1:0]      inverse;
        logic [MOD_WIDTH-1:0]      quotient;
        logic [DIVIDEND_WIDTH-1:0] dividend;
        logic [MOD_WIDTH-1:0]      divisor;
        logic [MOD_WIDTH-1:0]      modulus;
    } division_t;

    logic [MOD_WIDTH-1:0] modulus;
    division_t            awaited_divisions[$];

    // Operands stay below 2**31, so the product fits in 64 bits
    function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] m);
        return (a * b) % m;
    endfunction

    function automatic division_t predict_division(logic [DIVIDEND_WIDTH-1:0] dividend,
                                                   logic [MOD_WIDTH-1:0] divisor,
                                                   logic [MOD_WIDTH-1:0] m);
        division_t   res;
        logic [63:0] acc;
        logic [63:0] base;
        logic [63:0] power;
        res.dividend = dividend;
        res.divisor  = divisor;
        res.modulus  = m;
        res.inverse  = '0;
        res.quotient = '0;
        if (m >= 2) begin
            acc   = 64'd1;
            base  = 64'(divisor) % 64'(m);
            power = 64'(m) - 64'd2;
            for (int i = 0; i < MOD_WIDTH; i++) begin
                if (power[i])
                    acc = mul_reduce(acc, base, 64'(m));
                base = mul_reduce(base, base, 64'(m));
            end
            acc          = acc % 64'(m);
            res.inverse  = acc[MOD_WIDTH-1:0];
            acc          = mul_reduce(64'(dividend) % 64'(m), acc, 64'(m));
            res.quotient = acc[MOD_WIDTH-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus    <= MODULUS_RESET[MOD_WIDTH-1:0];
            awaited_divisions.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin : watch
            division_t due;
            int        errs;
            errs = 0;
            if (cfg.valid && cfg.ready)
                modulus <= cfg.data;
            if (operands.valid && operands.ready)
                awaited_divisions.push_back(
                    predict_division(operands.dividend, operands.divisor, modulus));
            if (results.valid && results.ready)
            begin
                if (awaited_divisions.size() == 0)
                begin
                    $display("%0t: result with no request pending: expected none, actual inverse %0d quotient %0d",
                             $time, results.inverse, results.quotient);
                    errs++;
                end
                else
                begin
                    due = awaited_divisions.pop_front();
                    if (results.inverse !== due.inverse)
                    begin
                        $display("%0t: inverse expected %0d actual %0d (dividend %0d divisor %0d modulus %0d)",
                                 $time, due.inverse, results.inverse,
                                 due.dividend, due.divisor, due.modulus);
                        errs++;
                    end
                    if (results.quotient !== due.quotient)
                    begin
                        $display("%0t: quotient expected %0d actual %0d (dividend %0d divisor %0d modulus %0d)",
                                 $time, due.quotient, results.quotient,
                                 due.dividend, due.divisor, due.modulus);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= awaited_divisions.size();
        end
    end

endmodule : modinv_checker

`default_nettype wire

// File: verif/tb_top.sv
// Testbench top for modular_inverse_divide: clock, reset, modulus writes,
// bursty operand requests and a stalling result sink; modinv_checker judges.
// Depends on modinv_pkg, modinv_if.sv, modinv_checker and the block itself.
`default_nettype none

module tb_top;

    import modinv_pkg::*;

    localparam int MOD_WIDTH = 30;
    localparam int PHASES    = 14;
    localparam int PHASE_LEN = 86;

    logic clk;
    logic rst_n;
    int   pending;
    int   fail_count;

    logic [MOD_WIDTH-1:0] cur_modulus;
    int                   burst_left = 0;
    bit [31:0]            stall_cycle = 0;
    bit [1:0]             stall_mode = 0;

    modinv_cfg_if #(.MOD_WIDTH(MOD_WIDTH)) cfg_ch ();
    modinv_in_if  #(.MOD_WIDTH(MOD_WIDTH)) op_ch ();
    modinv_out_if #(.MOD_WIDTH(MOD_WIDTH)) res_ch ();

    modular_inverse_divide #(.MOD_WIDTH(MOD_WIDTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .operands (op_ch),
        .results  (res_ch)
    );

    modinv_checker #(.MOD_WIDTH(MOD_WIDTH)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .operands   (op_ch),
        .results    (res_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result sink: stall pattern switches between four random modes
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 300 == 0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: res_ch.ready <= 1'b1;
            2'd1: res_ch.ready <= ($urandom_range(0, 3) == 0);
            2'd2: res_ch.ready <= (stall_cycle[3:0] != 4'd0);
            default: res_ch.ready <= (stall_cycle[6:0] > 7'd90);
        endcase
    end

    // Requests go out in bursts; valid drops only where a gap is inserted or the bench drains
    task automatic send_request(logic [DIVIDEND_WIDTH-1:0] dividend,
                                logic [MOD_WIDTH-1:0] divisor);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0)
            begin
                op_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        op_ch.valid    <= 1'b1;
        op_ch.dividend <= dividend;
        op_ch.divisor  <= divisor;
        do
            @(posedge clk);
        while (!op_ch.ready);
    endtask

    task automatic drain_and_idle();
        op_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_modulus(logic [MOD_WIDTH-1:0] m);
        drain_and_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_modulus = m;
    endtask

    initial
    begin
        logic [DIVIDEND_WIDTH-1:0] dividend;
        logic [MOD_WIDTH-1:0]      divisor;
        logic [MOD_WIDTH-1:0]      m;

        rst_n          = 1'b0;
        op_ch.valid    = 1'b0;
        op_ch.dividend = '0;
        op_ch.divisor  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus: zero divisor, divisor at/above modulus, field extremes
        cur_modulus = MODULUS_RESET[MOD_WIDTH-1:0];
        m = cur_modulus;
        send_request('0, '0);
        send_request(32'd1, 30'd1);
        send_request('1, '1);
        send_request(32'd5, m);
        send_request(32'd7, m + 30'd3);
        send_request(32'(m - 30'd1), m - 30'd1);
        send_request('1, 30'd2);
        send_request('0, 30'd12345);
        send_request(32'h8000_0000, 30'h2000_0000);
        send_request(32'(m), 30'd3);

        // Modulus two: exponent zero, inverse is one even for a zero divisor
        write_modulus(30'd2);
        send_request('0, '0);
        send_request('1, '1);
        send_request(32'd1, '0);
        send_request(32'd3, 30'd5);

        // Largest modulus, composite
        write_modulus('1);
        send_request(32'd12, 30'd4);
        send_request('1, '0);
        send_request(32'd100, '1);
        send_request(32'd7, 30'd7);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: m = 30'd3;
                1: m = 30'd7;
                2: m = 30'd65537;
                3: m = 30'd1000000007;
                4: m = 30'd1073741789;
                5: m = '1;
                6: m = 30'd998244353;
                7, 8, 9: m = 30'($urandom_range(2, 32'h3FFF_FFFF));
                10, 11: m = 30'($urandom_range(2, 255));
                12: m = 30'd2;
                default: m = 30'd13;
            endcase
            write_modulus(m);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                case ($urandom_range(0, 7))
                    0: dividend = '0;
                    1: dividend = '1;
                    2: dividend = 32'(m);
                    3: dividend = 32'(m) * $urandom_range(1, 3);
                    default: dividend = $urandom;
                endcase
                case ($urandom_range(0, 9))
                    0: divisor = '0;
                    1: divisor = 30'd1;
                    2: divisor = m - 30'd1;
                    3: divisor = m;
                    4: divisor = m + 30'($urandom_range(1, 1000));
                    5: divisor = '1;
                    6, 7: divisor = 30'($urandom % 32'(m));
                    default: divisor = 30'($urandom);
                endcase
                send_request(dividend, divisor);
            end
        end

        drain_and_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for the roughly 1250 requests: a hung run ends as a mismatch
    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : tb_top

`default_nettype wire
